// ===== hw/rtl/assert_macros.svh =====
// Assertion helper macros for the hashed page table insert block.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle.
`define HPT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked in the next cycle.
`define HPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/hpt_pkg.sv =====
// Shared types and constants for the hashed page table insert block.
// No dependencies.
package hpt_pkg;

  localparam int unsigned GROUP_COUNT_DEF = 2048;
  localparam int unsigned SLOTS_DEF       = 8;
  localparam int unsigned IDX_W           = 11;
  localparam int unsigned SLOT_FIELD_W    = 3;
  localparam int unsigned ENTRY_W         = 64;
  localparam int unsigned VALID_BIT       = 0;
  localparam int unsigned HASH_SEL_BIT    = 1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0]   group_index;
    logic [ENTRY_W-1:0] entry_high;
    logic [ENTRY_W-1:0] entry_low;
  } hpt_req_t;

  typedef struct packed {
    logic                    status;
    logic                    used_secondary;
    logic [SLOT_FIELD_W-1:0] slot_written;
    logic [IDX_W-1:0]        group_written;
  } hpt_rsp_t;

endpackage

// ===== hw/rtl/hashed_page_table_insert.sv =====
// Hashed page table insert engine: group store, free-slot search, write-back.
// Depends on hpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Insert requests are taken with start while busy is low. The primary group
// row is read from the entry store (one synchronous read) and the first slot
// whose valid bit is clear receives the entry with the
// hash-select bit cleared. If the primary group is full the secondary group
// (index XOR (GROUP_COUNT-1)) is read and searched the same way, and the
// entry goes in with hash-select set. Both full: status 1, nothing written.
// Every request yields exactly one result, shown on rsp_o for one cycle with
// done_o high; the receiver cannot stall it, so it must take it then.
// A request ends in ST_CHK1 if the primary group has room, else in ST_CHK2;
// the single store read port reads the two rows in turn. Busy stays high
// until the result is shown, so a new request is taken only once it is idle.
// When GROUP_COUNT is below 2048 the group index is first reduced modulo
// GROUP_COUNT by a reciprocal multiply and a subtract. After reset a clearing
// pass zeroes the high words of one group row per cycle, busy held high.
module hashed_page_table_insert #(
  parameter int unsigned GROUP_COUNT     = hpt_pkg::GROUP_COUNT_DEF,
  parameter int unsigned SLOTS_PER_GROUP = hpt_pkg::SLOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  hpt_pkg::hpt_req_t req_i,
  output logic             done_o,
  output hpt_pkg::hpt_rsp_t rsp_o
);
  import hpt_pkg::*;

  localparam int unsigned GW       = $clog2(GROUP_COUNT);
  localparam int unsigned SW       = (SLOTS_PER_GROUP > 1) ? $clog2(SLOTS_PER_GROUP) : 1;
  localparam bit          NEED_MOD = GROUP_COUNT < (2 ** IDX_W);
  localparam int unsigned MW       = 2 * IDX_W;
  localparam int unsigned PW       = IDX_W + MW + 1;
  localparam logic [GW:0]   GC     = (GW + 1)'(GROUP_COUNT);
  localparam logic [GW-1:0] GMASK  = GW'(GROUP_COUNT - 1);
  // ceil(2^MW / GROUP_COUNT): exact quotient for any index below 2^IDX_W
  localparam logic [MW:0]   RECIP  =
    (MW + 1)'(((64'd1 << MW) + 64'(GROUP_COUNT) - 64'd1) / 64'(GROUP_COUNT));
  localparam logic [IDX_W-1:0] GC_LO = IDX_W'(GROUP_COUNT);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_MOD2,
    ST_RD1,
    ST_CHK1,
    ST_CHK2
  } state_e;

  typedef logic [SLOTS_PER_GROUP-1:0][ENTRY_W-1:0] row_t;

  // Entry store, one row per group.
  row_t hi_mem [GROUP_COUNT];
  row_t lo_mem [GROUP_COUNT];
  row_t rd_row_q;

  state_e state_q, state_d;
  logic            done_q, done_d;
  hpt_rsp_t        rsp_q, rsp_d;
  logic [GW-1:0]   clr_q, clr_d;
  logic [IDX_W-1:0] rem_q, rem_d;
  logic [IDX_W-1:0] quot_q, quot_d;
  logic [GW-1:0]   grp_q, grp_d;
  logic [ENTRY_W-1:0] hi_q, lo_q;

  logic            accept;
  logic            clr_en;
  logic            rd_en;
  logic [GW-1:0]   rd_addr;
  logic            wr_en;
  logic            wr_sec;
  logic [ENTRY_W-1:0] wr_hi;
  logic [GW-1:0]   prim;
  logic [GW-1:0]   sec_x;
  logic [GW-1:0]   sec;
  logic [PW-1:0]   quot_prod;
  logic [MW-1:0]   quot_gc;
  logic [MW-1:0]   rem_sub;
  logic [SLOTS_PER_GROUP-1:0] free;
  logic            found;
  logic [SW-1:0]   fslot;
  logic [31:0]     slot_ext;
  logic [31:0]     grp_ext;

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;
  assign done_o = done_q;
  assign rsp_o  = rsp_q;
  assign clr_en = (state_q == ST_CLEAR);

  // Group index after reduction; remainder always fits GW bits.
  assign prim  = GW'(rem_q);
  assign sec_x = prim ^ GMASK;
  assign sec   = ({1'b0, sec_x} >= GC) ? GW'({1'b0, sec_x} - GC) : sec_x;

  // Modulo by reciprocal: quotient registered in ST_MOD, then remainder in ST_MOD2.
  assign quot_prod = PW'(rem_q) * PW'(RECIP);
  assign quot_gc   = MW'(quot_q) * MW'(GC_LO);
  assign rem_sub   = MW'(rem_q) - quot_gc;

  // First free slot of the row just read.
  always_comb begin
    fslot = '0;
    for (int s = SLOTS_PER_GROUP - 1; s >= 0; s--) begin
      free[s] = ~rd_row_q[s][VALID_BIT];
      if (free[s]) begin
        fslot = SW'(s);
      end
    end
  end
  assign found = |free;

  assign slot_ext = 32'(fslot);
  assign grp_ext  = 32'(grp_q);

  always_comb begin
    wr_hi               = hi_q;
    wr_hi[HASH_SEL_BIT] = wr_sec;
  end

  always_comb begin
    state_d = state_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    clr_d   = clr_q;
    rem_d   = rem_q;
    quot_d  = quot_q;
    grp_d   = grp_q;
    rd_en   = 1'b0;
    rd_addr = prim;
    wr_en   = 1'b0;
    wr_sec  = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == GMASK) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          rem_d   = req_i.group_index;
          state_d = NEED_MOD ? ST_MOD : ST_RD1;
        end
      end
      ST_MOD: begin
        quot_d  = quot_prod[MW +: IDX_W];
        state_d = ST_MOD2;
      end
      ST_MOD2: begin
        rem_d   = rem_sub[IDX_W-1:0];
        state_d = ST_RD1;
      end
      ST_RD1: begin
        rd_en   = 1'b1;
        rd_addr = prim;
        grp_d   = prim;
        state_d = ST_CHK1;
      end
      ST_CHK1: begin
        if (found) begin
          wr_en   = 1'b1;
          wr_sec  = 1'b0;
          done_d  = 1'b1;
          rsp_d   = '{status: STATUS_OK, used_secondary: 1'b0,
                      slot_written: slot_ext[SLOT_FIELD_W-1:0],
                      group_written: grp_ext[IDX_W-1:0]};
          state_d = ST_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = sec;
          grp_d   = sec;
          state_d = ST_CHK2;
        end
      end
      ST_CHK2: begin
        done_d  = 1'b1;
        state_d = ST_IDLE;
        if (found) begin
          wr_en  = 1'b1;
          wr_sec = 1'b1;
          rsp_d  = '{status: STATUS_OK, used_secondary: 1'b1,
                     slot_written: slot_ext[SLOT_FIELD_W-1:0],
                     group_written: grp_ext[IDX_W-1:0]};
        end else begin
          rsp_d  = '{status: STATUS_FULL, used_secondary: 1'b0,
                     slot_written: '0, group_written: '0};
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      done_q  <= 1'b0;
      rsp_q   <= '0;
      clr_q   <= '0;
      rem_q   <= '0;
      quot_q  <= '0;
      grp_q   <= '0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
      rsp_q   <= rsp_d;
      clr_q   <= clr_d;
      rem_q   <= rem_d;
      quot_q  <= quot_d;
      grp_q   <= grp_d;
    end
  end

  // Request payload, held for the write-back.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      hi_q <= req_i.entry_high;
      lo_q <= req_i.entry_low;
    end
  end

  // Store: one write (row clear or slot write) and one row read per cycle.
  always_ff @(posedge clk_i) begin
    if (clr_en) begin
      hi_mem[clr_q] <= '0;
    end else if (wr_en) begin
      hi_mem[grp_q][fslot] <= wr_hi;
      lo_mem[grp_q][fslot] <= lo_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_row_q <= hi_mem[rd_addr];
    end
  end

  `HPT_ASSERT_SAME(a_full_zero, done_o && (rsp_o.status == STATUS_FULL),
                   (!rsp_o.used_secondary && (rsp_o.slot_written == '0) &&
                    (rsp_o.group_written == '0)), "full result carries non-zero fields")
  `HPT_ASSERT_NEXT(a_accept_busy, accept, busy, "request accepted but block not busy")
  `HPT_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")
  `HPT_ASSERT_NEXT(a_write_ok, wr_en, (done_o && (rsp_o.status == STATUS_OK)),
                   "store written without a success result")

endmodule

// ===== verif/tb_hashed_page_table_insert.sv =====
// Self-checking testbench for the hashed page table insert block: directed table, then random.
// Depends on hpt_pkg and hashed_page_table_insert.
module tb_hashed_page_table_insert;
  import hpt_pkg::*;

  localparam int unsigned GROUPS = GROUP_COUNT_DEF;
  localparam int unsigned SLOTS = SLOTS_DEF;
  localparam logic [IDX_W-1:0] PAIR_MASK = IDX_W'(GROUPS - 1);
  // The clearing pass after reset keeps busy high until every group is cleared.
  // Every other stretch without a handshake is far shorter.
  localparam int unsigned WATCHDOG_LIMIT = 4 * GROUPS + 200;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned RANDOM_PHASES = 16;
  localparam int unsigned PHASE_REQUESTS = 100;

  typedef struct {
    hpt_req_t req;
    bit       typed;
    hpt_rsp_t want;
  } probe_row_t;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  hpt_req_t req_i;
  logic     done_o;
  hpt_rsp_t rsp_o;

  // Typed-in expectation that travels with the request being offered.
  bit       pin_typed;
  hpt_rsp_t pin_rsp;

  // Shadow of the stored high words; only the valid bits steer the search.
  bit [ENTRY_W-1:0] shadow_high [GROUPS*SLOTS];
  hpt_rsp_t         pending_rsp [$];
  probe_row_t       probe_rows [$];
  int unsigned      mismatches;
  int unsigned      idle_cycles;

  hashed_page_table_insert dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // First slot of a group whose valid bit is clear, -1 when the group is full.
  function automatic int first_free_slot(int unsigned grp);
    for (int s = 0; s < SLOTS; s++) begin
      if (!shadow_high[grp*SLOTS + s][VALID_BIT]) return s;
    end
    return -1;
  endfunction

  // Works out the result of one insert request and updates the shadow store.
  function automatic hpt_rsp_t predict_insert(hpt_req_t r);
    int unsigned      primary;
    int unsigned      secondary;
    int unsigned      grp;
    int               slot;
    logic [ENTRY_W-1:0] hi;
    hpt_rsp_t         rsp;
    primary   = r.group_index % GROUPS;
    secondary = (primary ^ (GROUPS - 1)) % GROUPS;
    hi        = r.entry_high;
    grp       = primary;
    rsp       = '0;
    slot      = first_free_slot(primary);
    if (slot < 0) begin
      grp = secondary;
      rsp.used_secondary = 1'b1;
      slot = first_free_slot(secondary);
    end
    if (slot < 0) begin
      // both groups full: nothing written, all other fields zero
      rsp = '0;
      rsp.status = STATUS_FULL;
      return rsp;
    end
    hi[HASH_SEL_BIT] = rsp.used_secondary;
    shadow_high[grp*SLOTS + slot] = hi;
    rsp.status        = STATUS_OK;
    rsp.slot_written  = SLOT_FIELD_W'(slot);
    rsp.group_written = IDX_W'(grp);
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input hpt_rsp_t want, input hpt_rsp_t seen);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected st/sec/slot/grp %0d/%0d/%0d/%0d, got %0d/%0d/%0d/%0d",
               $realtime, what, want.status, want.used_secondary, want.slot_written,
               want.group_written, seen.status, seen.used_secondary, seen.slot_written,
               seen.group_written);
    end
  endtask

  task automatic add_row(input logic [IDX_W-1:0] idx, input logic [ENTRY_W-1:0] hi,
                         input logic [ENTRY_W-1:0] lo, input bit typed, input hpt_rsp_t want);
    probe_row_t row;
    row.req.group_index = idx;
    row.req.entry_high  = hi;
    row.req.entry_low   = lo;
    row.typed           = typed;
    row.want            = want;
    probe_rows.push_back(row);
  endtask

  // Offers one request after a gap of idle cycles; called at a falling edge,
  // returns at the falling edge after the request is taken. With no gap start
  // simply stays high, so it never gets two assignments in one step.
  task automatic send_request(input hpt_req_t r, input bit typed, input hpt_rsp_t want,
                              input int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start     <= 1'b1;
    req_i     <= r;
    pin_typed <= typed;
    pin_rsp   <= want;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Scoreboard and watchdog. Inputs move at the falling edge, so everything
  // read here is settled; block outputs still hold their pre-edge values.
  always @(posedge clk_i) begin : scoreboard
    hpt_rsp_t want;
    hpt_rsp_t predicted;
    bit       taken;
    taken = rst_ni && start && !busy;
    if (rst_ni && done_o) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("result with no request outstanding", '0, rsp_o);
      end else begin
        want = pending_rsp.pop_front();
        if (want.status !== rsp_o.status || want.used_secondary !== rsp_o.used_secondary ||
            want.slot_written !== rsp_o.slot_written ||
            want.group_written !== rsp_o.group_written) begin
          report_mismatch("result mismatch", want, rsp_o);
        end
      end
    end
    if (taken) begin
      predicted = predict_insert(req_i);
      pending_rsp.push_back(pin_typed ? pin_rsp : predicted);
    end
    if (taken || (rst_ni && done_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog expired", $realtime);
        $display("hashed_page_table_insert regression: fail");
        $finish;
      end
    end
  end

  initial begin : stimulus
    hpt_req_t         r;
    logic [IDX_W-1:0] pool [3];
    bit               fast;
    int unsigned      gap;
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_i       = '0;
    pin_typed   = 1'b0;
    pin_rsp     = '0;
    mismatches  = 0;
    idle_cycles = 0;

    // Directed table. Pair 0 / 2047 is filled up from both sides.
    add_row(11'd0, '1, '1, 1'b1, hpt_rsp_t'{STATUS_OK, 1'b0, 3'd0, 11'd0});
    // invalid entry: lands in slot 0 but leaves it free
    add_row(11'd2047, '0, '0, 1'b1, hpt_rsp_t'{STATUS_OK, 1'b0, 3'd0, 11'd2047});
    // reuses slot 0; hash select given as 1 must be stored cleared
    add_row(11'd2047, 64'h3, 64'h5555_5555_5555_5555, 1'b0, '0);
    // slots 1..7 of group 0, then slots 1..7 of its secondary group 2047
    for (int i = 0; i < 14; i++) begin
      add_row(11'd0, {32'hA5A5_0000 | i, 32'h0F0F_1231}, {32'h5A5A_FFFF ^ i, 32'hF0F0_EDCE},
              1'b0, '0);
    end
    // both groups full, from either side
    add_row(11'd0, 64'hFFFF_0000_FFFF_0001, 64'h1, 1'b1,
            hpt_rsp_t'{STATUS_FULL, 1'b0, 3'd0, 11'd0});
    add_row(11'd2047, 64'h1, 64'h0, 1'b1, hpt_rsp_t'{STATUS_FULL, 1'b0, 3'd0, 11'd0});
    add_row(11'd2046, 64'hAAAA_AAAA_AAAA_AAAB, 64'h5555_5555_5555_5554, 1'b0, '0);
    add_row(11'd1, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b0, '0);

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (probe_rows[i]) begin
      send_request(probe_rows[i].req, probe_rows[i].typed, probe_rows[i].want,
                   $urandom_range(0, 9));
    end

    // Random part: each phase hammers a few group pairs so that primaries fill,
    // secondaries take over and both-full results turn up; the rest is noise.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      foreach (pool[k]) pool[k] = IDX_W'($urandom_range(0, GROUPS - 1));
      fast = (p % 4 == 3);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        if ($urandom_range(0, 9) < 8) begin
          r.group_index = pool[$urandom_range(0, 2)];
          if ($urandom_range(0, 1) == 1) r.group_index = r.group_index ^ PAIR_MASK;
        end else begin
          r.group_index = IDX_W'($urandom_range(0, GROUPS - 1));
        end
        r.entry_high = {$urandom, $urandom};
        r.entry_low  = {$urandom, $urandom};
        // mostly valid entries; an invalid one leaves its slot free
        r.entry_high[VALID_BIT] = ($urandom_range(0, 9) != 0);
        gap = fast ? 0 : $urandom_range(0, 9);
        send_request(r, 1'b0, '0, gap);
      end
    end
    start <= 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("hashed_page_table_insert regression: pass");
    end else begin
      $display("hashed_page_table_insert regression: fail");
    end
    $finish;
  end

endmodule
